// File: rtl/gosd_pkg.sv
// Shared types and constants for the gyro offset and stillness detector.
// Used by gosd_core, gosd_offset_div, the top level and the checker.
`timescale 1ns / 1ps
package gosd_pkg;

    localparam int CAL_SAMPLES_DEFAULT = 30;

    localparam int RATE_W    = 16;
    localparam int MOTION_W  = 18;
    localparam int THRESH_W  = 18;
    localparam int RUN_W     = 16;
    localparam int CFG_W     = 18;
    localparam int CFG_ADDR_W = 1;
    localparam int CAL_SUM_W = 22;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W   = 29;
    localparam int PROD_W    = CAL_SUM_W + RECIP_W;

    localparam int S_DATA_W  = 48;
    localparam int S_USER_W  = 1;
    localparam int M_DATA_W  = 72;

    localparam logic [CFG_ADDR_W-1:0] REG_MOTION_THRESHOLD   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_STILL_COUNT_NEEDED = 1'b1;

    localparam logic OP_SAMPLE    = 1'b0;
    localparam logic OP_CAL_START = 1'b1;

    localparam logic [THRESH_W-1:0] MOTION_THRESHOLD_RST   = 18'd20;
    localparam logic [RUN_W-1:0]    STILL_COUNT_NEEDED_RST = 16'd100;

    typedef logic signed [RATE_W-1:0] rate_t;

    typedef struct packed {
        logic  operation;
        rate_t gyro_z;
        rate_t gyro_y;
        rate_t gyro_x;
    } item_t;

    typedef struct packed {
        logic                offset_valid;
        logic                settled_once;
        logic                stable;
        logic [MOTION_W-1:0] motion;
        rate_t               rate_z;
        rate_t               rate_y;
        rate_t               rate_x;
    } result_t;

    typedef struct packed {
        logic                           start;
        logic [2:0][CAL_SUM_W-1:0]      sum;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [2:0][RATE_W-1:0] quot;
    } div_rsp_t;

endpackage

// File: rtl/gyro_offset_and_stillness_detector_unit.sv
// Top level: input beat register, detector core and output beat register.
// Depends on gosd_pkg, gosd_core and gosd_offset_div.
//
//   channel   dir  signals                          beat contents
//   s_        in   s_tvalid s_tready s_tdata s_tuser  gyro sample or calibration start
//   m_        out  m_tvalid m_tready m_tdata          corrected rates and status
//   cfg_      in   cfg_wr_en cfg_addr cfg_wdata       register write, no read-back
//
// Path: input register, core logic, output register. One beat per cycle while
// the divider is idle and the output is not stalled.
// After the last calibration sample, input holds while the offset divider
// finishes its multiply stages.
// Input holds while a sample waits behind a stalled output beat.
// A calibration start beat produces no output beat.
// Reset is synchronous; configuration returns to its defaults.
`timescale 1ns / 1ps
module gyro_offset_and_stillness_detector_unit #(
    parameter int CAL_SAMPLES = gosd_pkg::CAL_SAMPLES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // gyro_x, gyro_y, gyro_z
    input  logic [gosd_pkg::S_DATA_W-1:0]       s_tdata,
    // operation
    input  logic [gosd_pkg::S_USER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // rate_x, rate_y, rate_z, motion, stable, settled_once, offset_valid, zero pad
    output logic [gosd_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [gosd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gosd_pkg::CFG_W-1:0]          cfg_wdata
);
    import gosd_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t result;
    logic    core_busy;
    logic    fire;
    logic    out_room;

    assign out_room = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && !core_busy
                   && ((in_item_reg.operation == OP_CAL_START) || out_room);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= (out_valid_reg && !m_tready)
                          || (fire && (in_item_reg.operation == OP_SAMPLE));
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.operation <= s_tuser[0];
            in_item_reg.gyro_x    <= s_tdata[15:0];
            in_item_reg.gyro_y    <= s_tdata[31:16];
            in_item_reg.gyro_z    <= s_tdata[47:32];
        end
        if (fire && (in_item_reg.operation == OP_SAMPLE)) begin
            out_result_reg <= result;
        end
    end

    gosd_core #(
        .CAL_SAMPLES(CAL_SAMPLES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (in_item_reg),
        .fire      (fire),
        .result    (result),
        .busy      (core_busy)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - $bits(result_t))'(0), out_result_reg};

endmodule

// File: rtl/gosd_offset_div.sv
// Offset divider: calibration sums divided by the sample count, truncated toward zero.
// Reciprocal multiply over two registered stages; depends on gosd_pkg.
`timescale 1ns / 1ps
module gosd_offset_div #(
    parameter int CAL_SAMPLES = gosd_pkg::CAL_SAMPLES_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  gosd_pkg::div_req_t req,
    output gosd_pkg::div_rsp_t rsp
);
    import gosd_pkg::*;

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES);

    logic                       stage1_valid_reg;
    logic                       stage2_valid_reg;
    logic [2:0][CAL_SUM_W-1:0]  mag_reg;
    logic [2:0]                 neg1_reg;
    logic [2:0]                 neg2_reg;
    logic [2:0][PROD_W-1:0]     prod_reg;
    logic [2:0][CAL_SUM_W-1:0]  mag_next;
    logic [2:0][RATE_W-1:0]     quot;
    logic [2:0][RATE_W-1:0]     floor_q;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = req.sum[i][CAL_SUM_W-1] ? (~req.sum[i] + 1'b1) : req.sum[i];
            floor_q[i]  = prod_reg[i][RECIP_SHIFT +: RATE_W];
            quot[i]     = neg2_reg[i] ? (~floor_q[i] + 1'b1) : floor_q[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage1_valid_reg <= 1'b0;
            stage2_valid_reg <= 1'b0;
        end else begin
            stage1_valid_reg <= req.start;
            stage2_valid_reg <= stage1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            mag_reg <= mag_next;
            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= req.sum[i][CAL_SUM_W-1];
            end
        end
        if (stage1_valid_reg) begin
            neg2_reg <= neg1_reg;
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= PROD_W'(mag_reg[i]) * PROD_W'(RECIP);
            end
        end
    end

    assign rsp.busy = stage1_valid_reg | stage2_valid_reg;
    assign rsp.done = stage2_valid_reg;
    assign rsp.quot = quot;

endmodule

// File: rtl/gosd_core.sv
// Per-beat datapath: offset correction, motion sum, stillness run and calibration sums.
// Holds configuration and detector state; depends on gosd_pkg and gosd_offset_div.
`timescale 1ns / 1ps
module gosd_core #(
    parameter int CAL_SAMPLES = gosd_pkg::CAL_SAMPLES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gosd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gosd_pkg::CFG_W-1:0]          cfg_wdata,
    input  gosd_pkg::item_t                     item,
    input  logic                                fire,
    output gosd_pkg::result_t                   result,
    output logic                                busy
);
    import gosd_pkg::*;

    localparam int CNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);

    logic [THRESH_W-1:0]        motion_threshold_reg;
    logic [RUN_W-1:0]           still_count_needed_reg;
    logic [2:0][RATE_W-1:0]     prev_rate_reg;
    logic [RUN_W-1:0]           still_run_reg;
    logic                       stable_flag_reg;
    logic                       settled_flag_reg;
    logic                       offset_on_reg;
    logic [2:0][RATE_W-1:0]     axis_offset_reg;
    logic [2:0][CAL_SUM_W-1:0]  cal_sum_reg;
    logic [CNT_W-1:0]           cal_count_reg;
    logic                       calibrating_reg;

    logic [2:0][RATE_W-1:0]     raw;
    logic [2:0][RATE_W-1:0]     rate;
    logic [2:0][RATE_W:0]       diff;
    logic [2:0][RATE_W-1:0]     abs_diff;
    logic [MOTION_W-1:0]        motion;
    logic                       is_still;
    logic [RUN_W-1:0]           still_run_next;
    logic                       over_run;
    logic                       stable_flag_next;
    logic                       settled_flag_next;
    logic                       cal_last;
    logic [2:0][CAL_SUM_W-1:0]  cal_sum_next;
    logic                       sample_fire;
    logic                       start_fire;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    assign raw = {item.gyro_z, item.gyro_y, item.gyro_x};

    always_comb begin
        motion = '0;
        for (int i = 0; i < 3; i++) begin
            rate[i]         = offset_on_reg ? (raw[i] - axis_offset_reg[i]) : raw[i];
            diff[i]         = {prev_rate_reg[i][RATE_W-1], prev_rate_reg[i]}
                            - {rate[i][RATE_W-1], rate[i]};
            abs_diff[i]     = diff[i][RATE_W] ? RATE_W'(~diff[i] + 1'b1) : diff[i][RATE_W-1:0];
            motion          = motion + MOTION_W'(abs_diff[i]);
            cal_sum_next[i] = cal_sum_reg[i]
                            + {{(CAL_SUM_W-RATE_W){rate[i][RATE_W-1]}}, rate[i]};
        end
        is_still = motion < motion_threshold_reg;
        if (!is_still) begin
            still_run_next = '0;
        end else if (&still_run_reg) begin
            still_run_next = still_run_reg;
        end else begin
            still_run_next = still_run_reg + 1'b1;
        end
        over_run          = still_run_next > still_count_needed_reg;
        stable_flag_next  = over_run | (is_still & stable_flag_reg);
        settled_flag_next = over_run | settled_flag_reg;
        cal_last          = calibrating_reg && (cal_count_reg == CNT_LAST);
    end

    assign sample_fire = fire && (item.operation == OP_SAMPLE);
    assign start_fire  = fire && (item.operation == OP_CAL_START);

    assign div_req.start = sample_fire && cal_last;
    assign div_req.sum   = cal_sum_next;

    gosd_offset_div #(
        .CAL_SAMPLES(CAL_SAMPLES)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign busy = div_rsp.busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motion_threshold_reg   <= MOTION_THRESHOLD_RST;
            still_count_needed_reg <= STILL_COUNT_NEEDED_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MOTION_THRESHOLD:   motion_threshold_reg   <= cfg_wdata[THRESH_W-1:0];
                REG_STILL_COUNT_NEEDED: still_count_needed_reg <= cfg_wdata[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_rate_reg    <= '0;
            still_run_reg    <= '0;
            stable_flag_reg  <= 1'b0;
            settled_flag_reg <= 1'b0;
            offset_on_reg    <= 1'b0;
            axis_offset_reg  <= '0;
            cal_sum_reg      <= '0;
            cal_count_reg    <= '0;
            calibrating_reg  <= 1'b0;
        end else begin
            if (start_fire) begin
                offset_on_reg   <= 1'b0;
                calibrating_reg <= 1'b1;
                cal_count_reg   <= '0;
                cal_sum_reg     <= '0;
            end else if (sample_fire) begin
                prev_rate_reg    <= rate;
                still_run_reg    <= still_run_next;
                stable_flag_reg  <= stable_flag_next;
                settled_flag_reg <= settled_flag_next;
                if (calibrating_reg) begin
                    cal_sum_reg     <= cal_sum_next;
                    cal_count_reg   <= cal_last ? '0 : cal_count_reg + 1'b1;
                    calibrating_reg <= !cal_last;
                end
            end
            if (div_rsp.done) begin
                axis_offset_reg <= div_rsp.quot;
                offset_on_reg   <= 1'b1;
            end
        end
    end

    assign result.rate_x       = rate[0];
    assign result.rate_y       = rate[1];
    assign result.rate_z       = rate[2];
    assign result.motion       = motion;
    assign result.stable       = stable_flag_next;
    assign result.settled_once = settled_flag_next;
    assign result.offset_valid = offset_on_reg;

endmodule

// File: rtl/gosd_checker.sv
// Port-level checks on the detector's output beats, bound to the top level.
// Depends on gosd_pkg and gyro_offset_and_stillness_detector_unit.
`timescale 1ns / 1ps
module gosd_port_checks (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [gosd_pkg::M_DATA_W-1:0]     m_tdata
);
    import gosd_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    a_stable_implies_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[66] || m_tdata[67])
        else $error("stable without settled_once");

    a_motion_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[65:48] <= 18'd196605)
        else $error("motion out of range");

endmodule

bind gyro_offset_and_stillness_detector_unit gosd_port_checks u_gosd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
